/* hw/rtl/nsol_pkg.sv */
// Shared types and constants for the NNUE squared-clipped-ReLU output layer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package nsol_pkg;

	// Hidden layer size per perspective (default of the top level parameter)
	localparam int HIDDEN_UNITS_DEF = 256;

	// Field widths
	localparam int ADDR_W      = 9;
	localparam int STORE_DEPTH = 1 << ADDR_W;
	localparam int VAL_W       = 16;
	localparam int CLIP_W      = 15;
	localparam int QUANT_W     = 11;
	localparam int SCALE_W     = 11;
	localparam int BIAS_W      = 16;
	localparam int SQ_W        = 2 * CLIP_W;
	localparam int TERM_W      = SQ_W + 1 + VAL_W;
	localparam int SUM_W       = 48;
	localparam int SCORE_W     = 32;

	// Stream and configuration port widths
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Divider operand widths: product magnitude and clip*quant divisor
	localparam int DVD_W     = 60;
	localparam int DVS_W     = CLIP_W + QUANT_W;
	localparam int DIV_CNT_W = $clog2(DVD_W);
	localparam int MUL_CNT_W = $clog2(SCALE_W);

	// Sum queue between front and back
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// Register reset values
	localparam logic [CLIP_W-1:0]         CLIP_MAX_RST     = 15'd255;
	localparam logic [QUANT_W-1:0]        OUTPUT_QUANT_RST = 11'd64;
	localparam logic [SCALE_W-1:0]        EVAL_SCALE_RST   = 11'd400;
	localparam logic signed [BIAS_W-1:0]  OUTPUT_BIAS_RST  = 16'sd0;

	// Request kinds
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_ACT   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CLIP_MAX     = 2'd0,
		CFG_OUTPUT_QUANT = 2'd1,
		CFG_EVAL_SCALE   = 2'd2,
		CFG_OUTPUT_BIAS  = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [CLIP_W-1:0]        clip_max;
		logic [QUANT_W-1:0]       output_quant;
		logic [SCALE_W-1:0]       eval_scale;
		logic signed [BIAS_W-1:0] output_bias;
	} cfg_t;

	typedef struct packed {
		logic                    req_type;
		logic [ADDR_W-1:0]       address;
		logic                    perspective;
		logic                    side_to_move;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} item_t;

	typedef struct packed {
		logic             push;
		logic [SUM_W-1:0] sum;
	} sum_push_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV1,
		ST_SCALE_SETUP,
		ST_MUL,
		ST_DIV2_START,
		ST_DIV2,
		ST_DONE
	} back_state_t;

endpackage

`default_nettype wire

/* hw/rtl/nsol_front.sv */
// Front part: weight store, activation clip/square/multiply pipeline, running sum.
// Depends on nsol_pkg. Hands each finished evaluation sum to the sum queue.
`default_nettype none

module nsol_front #(
	parameter int HIDDEN_UNITS = nsol_pkg::HIDDEN_UNITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  nsol_pkg::item_t                  item,
	input  wire                              item_valid,
	output logic                             item_ready,
	input  wire [nsol_pkg::CLIP_W-1:0]       clip_max,
	output nsol_pkg::sum_push_t              push,
	input  wire                              q_full
);

	localparam logic [nsol_pkg::ADDR_W:0] HID = (nsol_pkg::ADDR_W + 1)'(HIDDEN_UNITS);

	logic signed [nsol_pkg::VAL_W-1:0] mem [nsol_pkg::STORE_DEPTH];

	logic                               adv;
	logic                               accept;
	logic                               in_range;
	logic [nsol_pkg::ADDR_W:0]          widx_far;
	logic [nsol_pkg::ADDR_W-1:0]        widx;
	logic [nsol_pkg::CLIP_W-1:0]        clip_eff;
	logic [nsol_pkg::CLIP_W-1:0]        v;

	logic                               valid_s1, valid_s2, valid_s3;
	logic                               last_s1, last_s2, last_s3;
	logic [nsol_pkg::CLIP_W-1:0]        v_s1;
	logic signed [nsol_pkg::VAL_W-1:0]  w_s1, w_s2;
	logic [nsol_pkg::SQ_W-1:0]          sq_s2;
	logic signed [nsol_pkg::TERM_W-1:0] term_s3;
	logic [nsol_pkg::SUM_W-1:0]         sum_q;
	logic [nsol_pkg::SUM_W-1:0]         sum_next;

	// Stall the whole pipe only when a finished sum meets a full queue
	assign adv        = !(valid_s3 && last_s3 && q_full);
	assign item_ready = adv;
	assign accept     = item_valid && adv;

	// Pick the weight half and clip the activation
	always_comb begin
		in_range = {1'b0, item.address} < HID;
		widx_far = {1'b0, item.address} + HID;
		widx     = (item.perspective == item.side_to_move) ? item.address
		                                                    : widx_far[nsol_pkg::ADDR_W-1:0];
		clip_eff = (clip_max == '0) ? nsol_pkg::CLIP_W'(1) : clip_max;
		if (!in_range || item.value[nsol_pkg::VAL_W-1]) begin
			v = '0;
		end else if (item.value[nsol_pkg::CLIP_W-1:0] > clip_eff) begin
			v = clip_eff;
		end else begin
			v = item.value[nsol_pkg::CLIP_W-1:0];
		end
	end

	// Weight store: write on accepted write beats
	always_ff @(posedge clk) begin
		if (accept && item.req_type == nsol_pkg::REQ_WRITE) begin
			mem[item.address] <= item.value;
		end
	end

	// Stage 1: registered weight read and clipped value
	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1    <= mem[widx];
			v_s1    <= v;
			last_s1 <= item.last;
		end
	end

	// Stage 2: square; stage 3: multiply by weight
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s2   <= {{nsol_pkg::CLIP_W{1'b0}}, v_s1} * {{nsol_pkg::CLIP_W{1'b0}}, v_s1};
			w_s2    <= w_s1;
			last_s2 <= last_s1;
			term_s3 <= $signed({1'b0, sq_s2}) * w_s2;
			last_s3 <= last_s2;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept && item.req_type == nsol_pkg::REQ_ACT;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 4: accumulate, wrap at 48 bits
	assign sum_next = sum_q + {{(nsol_pkg::SUM_W - nsol_pkg::TERM_W){term_s3[nsol_pkg::TERM_W-1]}},
	                           term_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (valid_s3 && adv) begin
			sum_q <= last_s3 ? '0 : sum_next;
		end
	end

	assign push.push = valid_s3 && last_s3 && !q_full;
	assign push.sum  = sum_next;

endmodule

`default_nettype wire

/* hw/rtl/nsol_fifo.sv */
// Short queue of finished evaluation sums between front and back.
// Depends on nsol_pkg.
`default_nettype none

module nsol_fifo (
	input  wire                             clk,
	input  wire                             arst_n,
	input  nsol_pkg::sum_push_t             push,
	output logic                            full,
	input  wire                             pop,
	output logic                            valid,
	output logic [nsol_pkg::SUM_W-1:0]      data
);

	logic [nsol_pkg::SUM_W-1:0]  mem_q [nsol_pkg::QDEPTH];
	logic [nsol_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [nsol_pkg::QCNT_W-1:0] cnt_q;
	logic                        do_push, do_pop;

	assign full    = cnt_q == nsol_pkg::QCNT_W'(nsol_pkg::QDEPTH);
	assign valid   = cnt_q != '0;
	assign data    = mem_q[rd_ptr_q];
	assign do_push = push.push && !full;
	assign do_pop  = pop && valid;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.sum;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/nsol_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nsol_pkg. Shared by both divisions of the back part.
`default_nettype none

module nsol_div (
	input  wire                 clk,
	input  wire                 arst_n,
	input  nsol_pkg::div_req_t  req,
	output nsol_pkg::div_rsp_t  rsp
);

	localparam int DVD_W = nsol_pkg::DVD_W;
	localparam int DVS_W = nsol_pkg::DVS_W;

	logic                          busy_q;
	logic                          done_q;
	logic [nsol_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]              quo_q;
	logic [DVS_W-1:0]              rem_q;
	logic [DVS_W-1:0]              dvs_q;
	logic [DVS_W:0]                trial;
	logic [DVS_W+1:0]              diff;

	// One restoring step
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = {1'b0, trial} - {2'b00, dvs_q};
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[DVS_W+1]) begin
				rem_q <= diff[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && cnt_q == '0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= nsol_pkg::DIV_CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

/* hw/rtl/nsol_back.sv */
// Back part: per-evaluation scaling sequencer, bias, scale, saturation, output register.
// Depends on nsol_pkg and nsol_div.
`default_nettype none

module nsol_back (
	input  wire                              clk,
	input  wire                              arst_n,
	input  nsol_pkg::cfg_t                   cfg,
	input  wire                              q_valid,
	input  wire [nsol_pkg::SUM_W-1:0]        q_data,
	output logic                             q_pop,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [nsol_pkg::M_TDATA_W-1:0]   m_tdata
);

	localparam int SUM_W = nsol_pkg::SUM_W;
	localparam int DVD_W = nsol_pkg::DVD_W;
	localparam int DVS_W = nsol_pkg::DVS_W;

	nsol_pkg::back_state_t state_q, state_d;
	nsol_pkg::div_req_t    div_req;
	nsol_pkg::div_rsp_t    div_rsp;

	logic                           neg1_q, neg2_q;
	logic signed [SUM_W:0]          res_q;
	logic [SUM_W-1:0]               mag_q;
	logic [DVD_W-1:0]               prod_q;
	logic [DVS_W-1:0]               dvs2_q;
	logic [nsol_pkg::MUL_CNT_W-1:0] cnt_q;
	logic                           m_tvalid_q;
	logic [nsol_pkg::M_TDATA_W-1:0] m_tdata_q;

	logic [nsol_pkg::CLIP_W-1:0]    clip_eff;
	logic [nsol_pkg::QUANT_W-1:0]   quant_eff;
	logic [SUM_W-1:0]               abs_sum;
	logic [SUM_W:0]                 q1_ext;
	logic [SUM_W:0]                 q1_signed;
	logic [SUM_W:0]                 res_neg;
	logic [DVD_W-1:0]               q2;
	logic [nsol_pkg::SCORE_W-1:0]   score;
	logic                           load_out;

	nsol_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Effective divisors and signed helpers
	always_comb begin
		clip_eff  = (cfg.clip_max == '0) ? nsol_pkg::CLIP_W'(1) : cfg.clip_max;
		quant_eff = (cfg.output_quant == '0) ? nsol_pkg::QUANT_W'(1) : cfg.output_quant;
		abs_sum   = q_data[SUM_W-1] ? (~q_data + 1'b1) : q_data;
		q1_ext    = {1'b0, div_rsp.quotient[SUM_W-1:0]};
		q1_signed = neg1_q ? (~q1_ext + 1'b1) : q1_ext;
		res_neg   = ~res_q + 1'b1;
		q2        = div_rsp.quotient;
	end

	// Saturate the final quotient to 32 signed bits
	always_comb begin
		if (!neg2_q) begin
			if (q2[DVD_W-1:nsol_pkg::SCORE_W-1] != '0) begin
				score = {1'b0, {(nsol_pkg::SCORE_W-1){1'b1}}};
			end else begin
				score = q2[nsol_pkg::SCORE_W-1:0];
			end
		end else begin
			if (q2[DVD_W-1:nsol_pkg::SCORE_W] != '0 ||
			    (q2[nsol_pkg::SCORE_W-1] && q2[nsol_pkg::SCORE_W-2:0] != '0)) begin
				score = {1'b1, {(nsol_pkg::SCORE_W-1){1'b0}}};
			end else begin
				score = ~q2[nsol_pkg::SCORE_W-1:0] + 1'b1;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			nsol_pkg::ST_IDLE: begin
				if (q_valid) state_d = nsol_pkg::ST_DIV1;
			end
			nsol_pkg::ST_DIV1: begin
				if (div_rsp.done) state_d = nsol_pkg::ST_SCALE_SETUP;
			end
			nsol_pkg::ST_SCALE_SETUP: begin
				state_d = nsol_pkg::ST_MUL;
			end
			nsol_pkg::ST_MUL: begin
				if (cnt_q == '0) state_d = nsol_pkg::ST_DIV2_START;
			end
			nsol_pkg::ST_DIV2_START: begin
				state_d = nsol_pkg::ST_DIV2;
			end
			nsol_pkg::ST_DIV2: begin
				if (div_rsp.done) state_d = nsol_pkg::ST_DONE;
			end
			nsol_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_tready) state_d = nsol_pkg::ST_IDLE;
			end
			default: begin
				state_d = nsol_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		q_pop            = 1'b0;
		load_out         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = prod_q;
		div_req.divisor  = dvs2_q;
		case (state_q)
			nsol_pkg::ST_IDLE: begin
				q_pop            = q_valid;
				div_req.start    = q_valid;
				div_req.dividend = DVD_W'(abs_sum);
				div_req.divisor  = DVS_W'(clip_eff);
			end
			nsol_pkg::ST_DIV2_START: begin
				div_req.start = 1'b1;
			end
			nsol_pkg::ST_DONE: begin
				load_out = !m_tvalid_q || m_tready;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nsol_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath: first quotient plus bias, shift-add scale, second divisor
	always_ff @(posedge clk) begin
		if (state_q == nsol_pkg::ST_IDLE && q_valid) begin
			neg1_q <= q_data[SUM_W-1];
		end
		if (state_q == nsol_pkg::ST_DIV1 && div_rsp.done) begin
			res_q <= $signed(q1_signed) +
			         $signed({{(SUM_W + 1 - nsol_pkg::BIAS_W){cfg.output_bias[nsol_pkg::BIAS_W-1]}},
			                  cfg.output_bias});
		end
		if (state_q == nsol_pkg::ST_SCALE_SETUP) begin
			neg2_q <= res_q[SUM_W];
			mag_q  <= res_q[SUM_W] ? res_neg[SUM_W-1:0] : res_q[SUM_W-1:0];
			dvs2_q <= {{nsol_pkg::QUANT_W{1'b0}}, clip_eff} * {{nsol_pkg::CLIP_W{1'b0}}, quant_eff};
			prod_q <= '0;
			cnt_q  <= nsol_pkg::MUL_CNT_W'(nsol_pkg::SCALE_W - 1);
		end
		if (state_q == nsol_pkg::ST_MUL) begin
			prod_q <= {prod_q[DVD_W-2:0], 1'b0} +
			          (cfg.eval_scale[cnt_q] ? DVD_W'(mag_q) : '0);
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= score;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

/* hw/rtl/nnue_screlu_output_layer_unit.sv */
// Top level of the NNUE squared-clipped-ReLU output layer: config registers,
// front pipeline, sum queue and back sequencer. Depends on nsol_pkg and all nsol_ modules.
//
//  Channel   Direction  Beat contents
//  s_*       in         tuser: req_type; tlast: last;
//                       tdata: address, perspective, side_to_move, value
//  m_*       out        tdata: score
//  cfg_*     in         write-only: clip_max, output_quant, eval_scale, output_bias
//
// The front takes one beat per cycle (weight write or activation) unless stalled; an activation
// passes through the weight-read, square and multiply stages before it reaches the running sum.
// In the back, each evaluation then runs through the shared
// one-bit-per-cycle divider (two 60-step divisions) and the 11-step shift-add scale.
// A two-entry sum queue lets the front run on; it stalls only on a last beat with the queue full.
// Reset clears control state and loads register defaults; the weight store is not cleared.
`default_nettype none

module nnue_screlu_output_layer_unit #(
	parameter int HIDDEN_UNITS = nsol_pkg::HIDDEN_UNITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// [8:0] address, [9] perspective, [10] side_to_move, [26:11] value, [31:27] zero
	input  wire [nsol_pkg::S_TDATA_W-1:0]      s_tdata,
	// [0] req_type
	input  wire                                s_tuser,
	input  wire                                s_tlast,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// [31:0] score
	output logic [nsol_pkg::M_TDATA_W-1:0]     m_tdata,
	input  wire                                cfg_we,
	input  wire [nsol_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [nsol_pkg::CFG_DATA_W-1:0]     cfg_data
);

	nsol_pkg::cfg_t      cfg_q;
	nsol_pkg::item_t     item;
	nsol_pkg::sum_push_t push;
	logic                q_full, q_valid, q_pop;
	logic [nsol_pkg::SUM_W-1:0] q_data;

	// Unpack the input beat
	always_comb begin
		item.req_type     = s_tuser;
		item.address      = s_tdata[8:0];
		item.perspective  = s_tdata[9];
		item.side_to_move = s_tdata[10];
		item.value        = s_tdata[26:11];
		item.last         = s_tlast;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clip_max     <= nsol_pkg::CLIP_MAX_RST;
			cfg_q.output_quant <= nsol_pkg::OUTPUT_QUANT_RST;
			cfg_q.eval_scale   <= nsol_pkg::EVAL_SCALE_RST;
			cfg_q.output_bias  <= nsol_pkg::OUTPUT_BIAS_RST;
		end else if (cfg_we) begin
			case (nsol_pkg::cfg_index_t'(cfg_index))
				nsol_pkg::CFG_CLIP_MAX:     cfg_q.clip_max     <= cfg_data[nsol_pkg::CLIP_W-1:0];
				nsol_pkg::CFG_OUTPUT_QUANT: cfg_q.output_quant <= cfg_data[nsol_pkg::QUANT_W-1:0];
				nsol_pkg::CFG_EVAL_SCALE:   cfg_q.eval_scale   <= cfg_data[nsol_pkg::SCALE_W-1:0];
				nsol_pkg::CFG_OUTPUT_BIAS:  cfg_q.output_bias  <= cfg_data[nsol_pkg::BIAS_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	nsol_front #(
		.HIDDEN_UNITS (HIDDEN_UNITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (s_tvalid),
		.item_ready (s_tready),
		.clip_max   (cfg_q.clip_max),
		.push       (push),
		.q_full     (q_full)
	);

	nsol_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.data   (q_data)
	);

	nsol_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire
